### rtl/sdkr_pkg.sv
package sdkr_pkg;

    localparam int NUM_SWITCHES = 5;
    localparam int PIN_W        = 5;
    localparam int CNT_W        = 16;
    localparam int APB_AW       = 4;
    localparam int APB_DW       = 32;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] REG_SAMPLE_INTERVAL = 2'd0;
    localparam logic [1:0] REG_PRESS_TIME      = 2'd1;
    localparam logic [1:0] REG_REPEAT_DELAY    = 2'd2;
    localparam logic [1:0] REG_REPEAT_PERIOD   = 2'd3;

    localparam logic [CNT_W-1:0] RST_SAMPLE_INTERVAL = CNT_W'(10);
    localparam logic [CNT_W-1:0] RST_PRESS_TIME      = CNT_W'(3);
    localparam logic [CNT_W-1:0] RST_REPEAT_DELAY    = CNT_W'(50);
    localparam logic [CNT_W-1:0] RST_REPEAT_PERIOD   = CNT_W'(10);

    typedef struct packed {
        logic [CNT_W-1:0] sample_interval;
        logic [CNT_W-1:0] press_time;
        logic [CNT_W-1:0] repeat_delay;
        logic [CNT_W-1:0] repeat_period;
    } t_thresh;

    typedef struct packed {
        logic eval;
        logic down;
    } t_sw_ctrl;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_WAIT   = 3'b010,
        ST_REPEAT = 3'b100
    } t_sw_state;

endpackage

### rtl/sdkr_if.sv
interface sdkr_in_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [sdkr_pkg::PIN_W-1:0]  pins_n;
    logic [sdkr_pkg::PIN_W-1:0]  clear_mask;

    modport source (output valid, output op, output pins_n, output clear_mask, input ready);
    modport sink   (input valid, input op, input pins_n, input clear_mask, output ready);
endinterface

interface sdkr_out_if;
    logic                        valid;
    logic                        ready;
    logic [sdkr_pkg::PIN_W-1:0]  flags;

    modport source (output valid, output flags, input ready);
    modport sink   (input valid, input flags, output ready);
endinterface

### rtl/sdkr_cfg.sv
module sdkr_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sdkr_pkg::APB_AW-1:0]   paddr,
    input  logic [sdkr_pkg::APB_DW-1:0]   pwdata,
    output logic [sdkr_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output sdkr_pkg::t_thresh             o_thresh
);

    sdkr_pkg::t_thresh       r_thresh;
    logic [1:0]              reg_idx;
    logic                    wr_en;
    logic [sdkr_pkg::CNT_W-1:0] rd_val;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh.sample_interval <= sdkr_pkg::RST_SAMPLE_INTERVAL;
            r_thresh.press_time      <= sdkr_pkg::RST_PRESS_TIME;
            r_thresh.repeat_delay    <= sdkr_pkg::RST_REPEAT_DELAY;
            r_thresh.repeat_period   <= sdkr_pkg::RST_REPEAT_PERIOD;
        end else if (wr_en) begin
            unique case (reg_idx)
                sdkr_pkg::REG_SAMPLE_INTERVAL:
                    r_thresh.sample_interval <= pwdata[sdkr_pkg::CNT_W-1:0];
                sdkr_pkg::REG_PRESS_TIME:
                    r_thresh.press_time      <= pwdata[sdkr_pkg::CNT_W-1:0];
                sdkr_pkg::REG_REPEAT_DELAY:
                    r_thresh.repeat_delay    <= pwdata[sdkr_pkg::CNT_W-1:0];
                sdkr_pkg::REG_REPEAT_PERIOD:
                    r_thresh.repeat_period   <= pwdata[sdkr_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            sdkr_pkg::REG_SAMPLE_INTERVAL: rd_val = r_thresh.sample_interval;
            sdkr_pkg::REG_PRESS_TIME:      rd_val = r_thresh.press_time;
            sdkr_pkg::REG_REPEAT_DELAY:    rd_val = r_thresh.repeat_delay;
            sdkr_pkg::REG_REPEAT_PERIOD:   rd_val = r_thresh.repeat_period;
            default:                       rd_val = '0;
        endcase
    end

    assign prdata   = {{(sdkr_pkg::APB_DW - sdkr_pkg::CNT_W){1'b0}}, rd_val};
    assign o_thresh = r_thresh;

endmodule

### rtl/sdkr_switch.sv
module sdkr_switch (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sdkr_pkg::t_sw_ctrl   i_ctrl,
    input  sdkr_pkg::t_thresh    i_thresh,
    output logic                 o_fire
);

    sdkr_pkg::t_sw_state         r_state, n_state;
    logic [sdkr_pkg::CNT_W-1:0]  r_hold, n_hold;
    logic [sdkr_pkg::CNT_W-1:0]  hold_inc;
    logic [sdkr_pkg::CNT_W-1:0]  limit;
    logic                        hit;

    assign hold_inc = r_hold + sdkr_pkg::CNT_W'(1);

    always_comb begin
        unique case (r_state)
            sdkr_pkg::ST_WAIT:   limit = i_thresh.repeat_delay;
            sdkr_pkg::ST_REPEAT: limit = i_thresh.repeat_period;
            default:             limit = i_thresh.press_time;
        endcase
    end

    assign hit    = hold_inc >= limit;
    assign o_fire = i_ctrl.eval && i_ctrl.down && hit;

    always_comb begin
        n_state = r_state;
        n_hold  = r_hold;
        if (i_ctrl.eval) begin
            if (!i_ctrl.down) begin
                n_state = sdkr_pkg::ST_IDLE;
                n_hold  = '0;
            end else if (hit) begin
                n_hold = '0;
                unique case (r_state)
                    sdkr_pkg::ST_WAIT,
                    sdkr_pkg::ST_REPEAT: n_state = sdkr_pkg::ST_REPEAT;
                    default:             n_state = sdkr_pkg::ST_WAIT;
                endcase
            end else begin
                n_hold = hold_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdkr_pkg::ST_IDLE;
            r_hold  <= '0;
        end else begin
            r_state <= n_state;
            r_hold  <= n_hold;
        end
    end

endmodule

### rtl/switch_debounce_key_repeat_top.sv
// channel  dir  handshake     word
// i_in     in   valid/ready   op, pins_n, clear_mask
// o_out    out  valid/ready   flags
// cfg      in   apb write     sample_interval, press_time, repeat_delay, repeat_period
//
// one word per cycle sustained while the output is not stalled; an accepted word passes
// through the input register and then the result register before output valid rises,
// so both registers lie between the input accept and the earliest output accept
// synchronous active-low reset clears both valid bits, prescaler, switches and pending flags
// a stalled output holds the result register and backs up into the input register
module switch_debounce_key_repeat_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sdkr_in_if.sink                       i_in,
    sdkr_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sdkr_pkg::APB_AW-1:0]   paddr,
    input  logic [sdkr_pkg::APB_DW-1:0]   pwdata,
    output logic [sdkr_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    sdkr_pkg::t_thresh              thresh;

    logic                           r_in_valid;
    logic                           r_op;
    logic [sdkr_pkg::PIN_W-1:0]     r_pins_n;
    logic [sdkr_pkg::PIN_W-1:0]     r_clear_mask;

    logic                           r_out_valid;
    logic [sdkr_pkg::PIN_W-1:0]     r_out_flags;

    logic [sdkr_pkg::CNT_W-1:0]     r_prescale, n_prescale;
    logic [sdkr_pkg::PIN_W-1:0]     r_pending, n_pending;
    logic [sdkr_pkg::PIN_W-1:0]     n_out_flags;

    logic                           advance;
    logic                           in_take;
    logic                           is_tick;
    logic [sdkr_pkg::CNT_W-1:0]     prescale_inc;
    logic                           eval;
    logic [sdkr_pkg::NUM_SWITCHES-1:0] fire;
    logic [sdkr_pkg::PIN_W-1:0]     new_flags;

    sdkr_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_thresh (thresh)
    );

    assign advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_take  = i_in.valid && i_in.ready;

    assign is_tick      = (r_op == sdkr_pkg::OP_TICK);
    assign prescale_inc = r_prescale + sdkr_pkg::CNT_W'(1);
    assign eval         = advance && is_tick && (prescale_inc >= thresh.sample_interval);

    for (genvar gi = 0; gi < sdkr_pkg::NUM_SWITCHES; gi++) begin : g_sw
        sdkr_pkg::t_sw_ctrl ctrl;
        logic               down;
        if (gi < sdkr_pkg::PIN_W) begin : g_pin
            assign down = !r_pins_n[gi];
        end else begin : g_nopin
            assign down = 1'b0;
        end
        assign ctrl = '{eval: eval, down: down};
        sdkr_switch u_sw (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (ctrl),
            .i_thresh (thresh),
            .o_fire   (fire[gi])
        );
    end

    always_comb begin
        new_flags = '0;
        for (int k = 0; k < sdkr_pkg::NUM_SWITCHES; k++) begin
            if (k < sdkr_pkg::PIN_W) begin
                new_flags[k] = fire[k];
            end
        end
    end

    always_comb begin
        n_prescale  = r_prescale;
        n_pending   = r_pending;
        n_out_flags = r_out_flags;
        if (advance) begin
            if (is_tick) begin
                n_prescale  = eval ? '0 : prescale_inc;
                n_pending   = r_pending | new_flags;
                n_out_flags = r_pending | new_flags;
            end else begin
                n_pending   = r_pending & ~r_clear_mask;
                n_out_flags = r_pending & r_clear_mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prescale  <= '0;
            r_pending   <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            r_prescale <= n_prescale;
            r_pending  <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op         <= i_in.op;
            r_pins_n     <= i_in.pins_n;
            r_clear_mask <= i_in.clear_mask;
        end
        r_out_flags <= n_out_flags;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.flags = r_out_flags;

    a_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !is_tick) |=> ((r_pending & $past(r_clear_mask)) == '0))
        else $error("read left masked flags pending");

    a_read_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !is_tick) |=> ((r_out_flags & ~$past(r_clear_mask)) == '0))
        else $error("read word carries unmasked flags");

    a_pending_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_pending))
        else $error("pending flags changed without a word");

    a_prescale_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eval |=> (r_prescale == '0))
        else $error("prescaler not cleared after evaluation");

    a_tick_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && is_tick) |=> (r_out_flags == r_pending))
        else $error("tick word differs from pending flags");

endmodule
